FILE: hw/rtl/f2h_pkg.sv
`timescale 1ns / 1ps
package f2h_pkg;

    localparam logic MODE_S2H = 1'b0;
    localparam logic MODE_H2S = 1'b1;

    localparam logic [30:0] SGL_EXP_MASK = 31'h7f800000;
    localparam logic [30:0] HALF_OVF_MAG = 31'h477ff000;
    localparam logic [7:0]  EXP_REBIAS   = 8'd112;
    localparam logic [14:0] HALF_QNAN    = 15'h7e00;
    localparam logic [14:0] HALF_INF     = 15'h7c00;

    // Class of a single-to-half conversion, settled in the first stage.
    localparam logic [1:0] CLS_NORM = 2'd0;
    localparam logic [1:0] CLS_SUB  = 2'd1;
    localparam logic [1:0] CLS_FIX  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic        sign;
        logic [1:0]  cls;
        logic [14:0] fixed;
        logic [30:0] mag;
        logic [4:0]  sh;
        logic [15:0] h;
    } s1_t;

    typedef struct packed {
        logic        mode;
        logic        sign;
        logic [30:0] q;
        logic        rnd_up;
        logic [31:0] wide;
    } s2_t;

endpackage

FILE: hw/rtl/fp32_fp16_convert_core.sv
`timescale 1ns / 1ps
// Channel | Signals                  | Direction | Notes
// in      | in_valid, in_stall, mode, value | sink   | one conversion per transfer
// out     | out_valid, out_stall, result    | source | one result per transfer
//
// Three register stages: classify and align, shift and round decision,
// increment and pack. One transfer enters per cycle while in_stall is low.
// rst_n clears only the stage valid bits, asynchronously.
// The stall from the output travels back through per-stage enables: any stage
// whose successor holds a result and is stalled keeps its contents, and empty
// stages fill in, so no transfer is lost or repeated.
module fp32_fp16_convert_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result
);

    f2h_pkg::s1_t s1_reg, s1_next;
    f2h_pkg::s2_t s2_reg, s2_next;
    logic [31:0]  s3_reg, s3_next;
    logic         v1_reg, v2_reg, v3_reg;
    logic         en3, en2, en1;

    // Each stage advances when the one after it is empty or advancing.
    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    // Stage 1: classify and compute the shift for a single.
    logic [30:0] a;
    logic [7:0]  e;
    logic [4:0]  he;
    logic [9:0]  hm;
    always_comb
    begin
        a  = value[30:0];
        e  = a[30:23];
        s1_next       = '0;
        s1_next.mode  = mode;
        s1_next.h     = value[15:0];
        s1_next.sign  = (mode == f2h_pkg::MODE_S2H) ? value[31] : value[15];
        s1_next.fixed = '0;
        s1_next.mag   = a - {f2h_pkg::EXP_REBIAS, 23'd0};
        s1_next.sh    = 5'd13;
        he = value[14:10];
        hm = value[9:0];
        if (a > f2h_pkg::SGL_EXP_MASK)
        begin
            s1_next.cls   = f2h_pkg::CLS_FIX;
            s1_next.fixed = f2h_pkg::HALF_QNAN;
        end
        else if (a >= f2h_pkg::HALF_OVF_MAG)
        begin
            s1_next.cls   = f2h_pkg::CLS_FIX;
            s1_next.fixed = f2h_pkg::HALF_INF;
        end
        else if (e >= f2h_pkg::EXP_REBIAS + 8'd1)
        begin
            s1_next.cls = f2h_pkg::CLS_NORM;
        end
        else if (e < 8'd102)
        begin
            s1_next.cls = f2h_pkg::CLS_FIX;
        end
        else
        begin
            s1_next.cls = f2h_pkg::CLS_SUB;
            s1_next.mag = {7'd0, 1'b1, a[22:0]};
            s1_next.sh  = 5'(8'd126 - e);
        end
        if (he == 5'd0 && hm != 10'd0)
        begin
            s1_next.h[14:10] = '0;
        end
    end

    // Stage 2: shift with round decision, and widen a half.
    logic [30:0] rem, halfway, q;
    logic [3:0]  lz;
    logic [9:0]  nm;
    logic [4:0]  ph;
    logic [9:0]  pm;
    always_comb
    begin
        q       = s1_reg.mag >> s1_reg.sh;
        rem     = s1_reg.mag & ((31'd1 << s1_reg.sh) - 31'd1);
        halfway = 31'd1 << (s1_reg.sh - 5'd1);
        s2_next.mode   = s1_reg.mode;
        s2_next.sign   = s1_reg.sign;
        s2_next.q      = (s1_reg.cls == f2h_pkg::CLS_FIX) ? {16'd0, s1_reg.fixed} : q;
        s2_next.rnd_up = (s1_reg.cls != f2h_pkg::CLS_FIX)
                         && (rem > halfway || (rem == halfway && q[0]));
        ph = s1_reg.h[14:10];
        pm = s1_reg.h[9:0];
        lz = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (pm[i])
            begin
                lz = 4'(9 - i);
            end
        end
        nm = 10'(pm << (lz + 4'd1));
        if (ph == 5'h1f)
        begin
            s2_next.wide = {s1_reg.sign, 8'hff, (pm != 10'd0), pm[8:0], 13'd0};
            if (pm != 10'd0)
            begin
                s2_next.wide[22] = 1'b1;
            end
        end
        else if (ph == 5'd0)
        begin
            if (pm == 10'd0)
            begin
                s2_next.wide = {s1_reg.sign, 31'd0};
            end
            else
            begin
                s2_next.wide = {s1_reg.sign, 8'(8'd112 - {4'd0, lz}), nm, 13'd0};
            end
        end
        else
        begin
            s2_next.wide = {s1_reg.sign, 8'({3'd0, ph} + f2h_pkg::EXP_REBIAS), pm, 13'd0};
        end
    end

    // Stage 3: apply the round increment and pack.
    logic [30:0] qr;
    always_comb
    begin
        qr = s2_reg.q + {30'd0, s2_reg.rnd_up};
        if (s2_reg.mode == f2h_pkg::MODE_S2H)
        begin
            s3_next = {16'd0, s2_reg.sign, qr[14:0]};
        end
        else
        begin
            s3_next = s2_reg.wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign result    = s3_reg;

    // A full pipe with a stalled output must push back on the input.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && out_stall) |-> in_stall)
        else $error("input accepted into full stalled pipe");

    // A held result stays put while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result)))
        else $error("stalled result changed");

    // Single-to-half results keep the upper half clear.
    a_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && s2_reg.mode == f2h_pkg::MODE_S2H)
        |=> (result[31:16] == 16'd0))
        else $error("upper half not clear");

endmodule
